// File: hw/rtl/rc3_pkg.sv
`default_nettype none

package rc3_pkg;

    localparam int PIX_W          = 8;
    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 8;
    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int MIN_DIM        = 3;
    localparam int ADDR_W         = $clog2(MAX_WIDTH);
    localparam int ROW_W          = $clog2(MAX_HEIGHT);
    localparam int DIM_W          = 11;
    localparam int CFG_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int DATA_W         = 24;
    localparam int PROD_W         = COEF_W + PIX_W;
    localparam int COL_W          = PROD_W + 2;
    localparam int SUM_W          = PROD_W + 4;
    localparam int PIX_MAX        = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP    = 3'd0,
        CFG_COEF_MIDDLE = 3'd1,
        CFG_COEF_BOTTOM = 3'd2,
        CFG_WIDTH       = 3'd3,
        CFG_HEIGHT      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] top;
        logic signed [COEF_W-1:0] mid;
        logic signed [COEF_W-1:0] bot;
    } coef_col_t;

    typedef struct packed {
        logic signed [COL_W-1:0] red;
        logic signed [COL_W-1:0] green;
        logic signed [COL_W-1:0] blue;
    } chan_sum_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/rc3_line_buffer.sv
`default_nettype none

module rc3_line_buffer (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [rc3_pkg::ADDR_W-1:0] addr,
    input  wire rc3_pkg::pixel_t          px,
    input  wire logic                     up_we,
    input  wire logic [rc3_pkg::ADDR_W-1:0] up_addr,
    output rc3_pkg::pixel_t               top,
    output rc3_pkg::pixel_t               mid
);
    import rc3_pkg::*;

    pixel_t mem_upper [MAX_WIDTH];
    pixel_t mem_lower [MAX_WIDTH];
    pixel_t top_reg;
    pixel_t mid_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            top_reg        <= mem_upper[addr];
            mid_reg        <= mem_lower[addr];
            mem_lower[addr] <= px;
        end
        if (up_we)
        begin
            mem_upper[up_addr] <= mid_reg;
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rc3_cell.sv
`default_nettype none

module rc3_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift_en,
    input  wire logic               en,
    input  wire rc3_pkg::column_t   col_in,
    input  wire rc3_pkg::coef_col_t coefs,
    output rc3_pkg::column_t        col_out,
    output rc3_pkg::chan_sum_t      sums
);
    import rc3_pkg::*;

    column_t                  col_reg;
    logic signed [PROD_W-1:0] prod_reg [3][3];
    chan_sum_t                sum_reg;
    pixel_t                   pix_row  [3];
    logic signed [COEF_W-1:0] coef_row [3];

    function automatic logic signed [PROD_W-1:0] mul(
        input logic signed [COEF_W-1:0] c,
        input logic [PIX_W-1:0]         p
    );
        logic signed [PROD_W-1:0] r;
        r = PROD_W'(c) * PROD_W'($signed({1'b0, p}));
        return r;
    endfunction

    assign pix_row[0]  = col_reg.top;
    assign pix_row[1]  = col_reg.mid;
    assign pix_row[2]  = col_reg.bot;
    assign coef_row[0] = coefs.top;
    assign coef_row[1] = coefs.mid;
    assign coef_row[2] = coefs.bot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i][0] <= mul(coef_row[i], pix_row[i].red);
                prod_reg[i][1] <= mul(coef_row[i], pix_row[i].green);
                prod_reg[i][2] <= mul(coef_row[i], pix_row[i].blue);
            end
            sum_reg.red   <= COL_W'(prod_reg[0][0]) + COL_W'(prod_reg[1][0])
                           + COL_W'(prod_reg[2][0]);
            sum_reg.green <= COL_W'(prod_reg[0][1]) + COL_W'(prod_reg[1][1])
                           + COL_W'(prod_reg[2][1]);
            sum_reg.blue  <= COL_W'(prod_reg[0][2]) + COL_W'(prod_reg[1][2])
                           + COL_W'(prod_reg[2][2]);
        end
    end

    assign col_out = col_reg;
    assign sums    = sum_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rc3_out.sv
`default_nettype none

module rc3_out (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire rc3_pkg::chan_sum_t         sums [3],
    input  wire logic                       v_in,
    input  wire rc3_pkg::tag_t              tag_in,
    input  wire logic                       m_tready,
    output logic                            m_tvalid,
    output logic [rc3_pkg::DATA_W-1:0]      m_tdata,
    output logic                            m_tlast,
    output logic                            m_tuser,
    output logic                            load
);
    import rc3_pkg::*;

    logic              tvalid_reg;
    logic [DATA_W-1:0] tdata_reg;
    logic              tlast_reg;
    logic              tuser_reg;
    logic [PIX_W-1:0]  red_c;
    logic [PIX_W-1:0]  green_c;
    logic [PIX_W-1:0]  blue_c;

    function automatic logic [PIX_W-1:0] clamp(
        input logic signed [COL_W-1:0] a,
        input logic signed [COL_W-1:0] b,
        input logic signed [COL_W-1:0] c
    );
        logic signed [SUM_W-1:0] s;
        logic [PIX_W-1:0]        r;
        s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
        if (s[SUM_W-1] || (s == '0))
        begin
            r = '0;
        end
        else if (|s[SUM_W-1:COEF_FRAC_BITS+PIX_W])
        begin
            r = PIX_W'(PIX_MAX);
        end
        else
        begin
            r = s[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
        end
        return r;
    endfunction

    always_comb
    begin
        red_c   = clamp(sums[0].red,   sums[1].red,   sums[2].red);
        green_c = clamp(sums[0].green, sums[1].green, sums[2].green);
        blue_c  = clamp(sums[0].blue,  sums[1].blue,  sums[2].blue);
    end

    assign load = !tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else if (load)
        begin
            tvalid_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= {blue_c, green_c, red_c};
            tlast_reg <= tag_in.row_end;
            tuser_reg <= tag_in.frame_end;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rgb_convolution_3x3.sv
// 3x3 convolution filter for an RGB pixel stream in raster order.
// Input beats on s_axis carry one pixel each; the frame size comes from the
// image_width and image_height registers (clamped to 3..1024). Output beats
// on m_axis carry one filtered pixel for each window that fits inside the
// frame, (height-2) x (width-2) beats per frame; tlast marks the last pixel
// of an output row and tuser the last pixel of the frame.
// Coefficients are three rows of three signed Q7.8 values, written through
// cfg_we/cfg_index/cfg_data while the stream is idle.
// Throughput: one pixel per clock. An output beat is formed from the input beat
// that completes its window through line buffer read, window shift, products,
// column sums and the clamp into the output register.
// The limit is the line buffer memories, each read and written once per pixel.
// When the receiver stalls, the pipeline keeps taking pixels until a result
// reaches the stage in front of the output register; then s_axis_tready
// drops until the waiting beat is taken.
// Reset clears the counters, the window and the pipeline valid bits and loads the
// default registers (640x480, 1.0 on the middle-row tap of the oldest column).
// The line buffers are not cleared: the first two rows fill them and give no output.
`default_nettype none

module rgb_convolution_3x3 (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [rc3_pkg::DATA_W-1:0]    s_axis_tdata,  // red_in, green_in, blue_in
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [rc3_pkg::DATA_W-1:0]         m_axis_tdata,  // red_out, green_out, blue_out
    output logic                               m_axis_tlast,  // row_end
    output logic                               m_axis_tuser,  // frame_end
    input  wire logic                          cfg_we,
    input  wire logic [rc3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rc3_pkg::CFG_W-1:0]     cfg_data
);
    import rc3_pkg::*;

    logic [CFG_W-1:0]  coef_top_reg;
    logic [CFG_W-1:0]  coef_mid_reg;
    logic [CFG_W-1:0]  coef_bot_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;

    logic [ADDR_W-1:0] col_cnt_reg;
    logic [ADDR_W-1:0] col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [ROW_W-1:0]  row_cnt_next;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [ADDR_W-1:0] w_last;
    logic [ROW_W-1:0]  h_last;
    logic              last_col;
    logic              last_row;
    logic              emit;

    logic              en;
    logic              load;
    logic              accept;

    pixel_t            px_in;
    pixel_t            px1_reg;
    logic [ADDR_W-1:0] idx1_reg;
    logic              v1_reg;
    logic              emit1_reg;
    tag_t              tag1_reg;
    logic              v2_reg;
    tag_t              tag2_reg;
    logic              v3_reg;
    tag_t              tag3_reg;
    logic              v4_reg;
    tag_t              tag4_reg;

    pixel_t            top_rd;
    pixel_t            mid_rd;
    column_t           link [4];
    coef_col_t         coef_col [3];
    chan_sum_t         sums [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= '0;
            coef_mid_reg <= CFG_W'(256);
            coef_bot_reg <= '0;
            width_reg    <= DIM_W'(640);
            height_reg   <= DIM_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_TOP:    coef_top_reg <= cfg_data;
                CFG_COEF_MIDDLE: coef_mid_reg <= cfg_data;
                CFG_COEF_BOTTOM: coef_bot_reg <= cfg_data;
                CFG_WIDTH:       width_reg    <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:      height_reg   <= cfg_data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg < DIM_W'(MIN_DIM))
            w_eff = DIM_W'(MIN_DIM);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        priority if (height_reg < DIM_W'(MIN_DIM))
            h_eff = DIM_W'(MIN_DIM);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        w_last = ADDR_W'(w_eff - DIM_W'(1));
        h_last = ROW_W'(h_eff - DIM_W'(1));
    end

    assign en            = load || !v4_reg;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    assign px_in.red   = s_axis_tdata[PIX_W-1:0];
    assign px_in.green = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign px_in.blue  = s_axis_tdata[3*PIX_W-1:2*PIX_W];

    assign last_col = col_cnt_reg >= w_last;
    assign last_row = row_cnt_reg >= h_last;
    assign emit     = (row_cnt_reg >= ROW_W'(2)) && (col_cnt_reg >= ADDR_W'(2));

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = last_row ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (en)
            begin
                v1_reg <= accept;
                v2_reg <= v1_reg && emit1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg            <= px_in;
            idx1_reg           <= col_cnt_reg;
            emit1_reg          <= emit;
            tag1_reg.row_end   <= last_col;
            tag1_reg.frame_end <= last_col && last_row;
            tag2_reg           <= tag1_reg;
            tag3_reg           <= tag2_reg;
            tag4_reg           <= tag3_reg;
        end
    end

    rc3_line_buffer u_line_buffer (
        .clk     (clk),
        .rd_en   (accept),
        .addr    (col_cnt_reg),
        .px      (px_in),
        .up_we   (en && v1_reg),
        .up_addr (idx1_reg),
        .top     (top_rd),
        .mid     (mid_rd)
    );

    assign link[3].top = top_rd;
    assign link[3].mid = mid_rd;
    assign link[3].bot = px1_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_cell
        assign coef_col[k].top = $signed(coef_top_reg[COEF_W*k +: COEF_W]);
        assign coef_col[k].mid = $signed(coef_mid_reg[COEF_W*k +: COEF_W]);
        assign coef_col[k].bot = $signed(coef_bot_reg[COEF_W*k +: COEF_W]);

        rc3_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (en && v1_reg),
            .en       (en),
            .col_in   (link[k+1]),
            .coefs    (coef_col[k]),
            .col_out  (link[k]),
            .sums     (sums[k])
        );
    end

    rc3_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .sums     (sums),
        .v_in     (v4_reg),
        .tag_in   (tag4_reg),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .m_tuser  (m_axis_tuser),
        .load     (load)
    );

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end without row end");

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col) |=> (col_cnt_reg == '0))
        else $error("column count did not wrap at row end");

    a_window_to_product: assert property (@(posedge clk) disable iff (!rst_n)
        (en && v1_reg && emit1_reg) |=> v2_reg)
        else $error("complete window lost before product stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !load) |=> (v4_reg && $stable(tag4_reg)))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// File: bench/rgb_convolution_3x3_test.sv
`default_nettype none

module rgb_convolution_3x3_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rc3_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_PIXELS = 450;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned MAX_REPORTS = 50;

    typedef struct packed {
        pixel_t pix;
        logic   row_end;
        logic   frame_end;
    } out_pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 cfg_we = 1'b0;
    cfg_index_t           cfg_index = CFG_COEF_TOP;
    logic [CFG_W-1:0]     cfg_data = '0;

    rgb_convolution_3x3 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // filter state as the block should hold it
    logic [CFG_W-1:0] coef_rows [3] = '{48'd0, 48'd256, 48'd0};
    logic [DIM_W-1:0] width_reg = 11'd640;
    logic [DIM_W-1:0] height_reg = 11'd480;
    pixel_t           line_upper [MAX_WIDTH];
    pixel_t           line_lower [MAX_WIDTH];
    pixel_t           window [9] = '{default: '0};
    int unsigned      col_cnt = 0;
    int unsigned      row_cnt = 0;

    pixel_t           pixel_q [$];
    out_pixel_t       filtered_q [$];

    bit               send_mode = 1'b0;
    bit               recv_mode = 1'b0;
    int unsigned      send_gap = 0;
    int unsigned      recv_stall = 0;
    bit               hold_request = 1'b0;
    bit               hold_done = 1'b0;
    int unsigned      hold_left = 0;

    int unsigned      error_count = 0;
    int unsigned      pixels_sent = 0;
    int unsigned      beats_checked = 0;
    int unsigned      frame_ends = 0;
    int unsigned      resizes = 0;
    int unsigned      cycle_count = 0;

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(v);
    endfunction

    function automatic logic [PIX_W-1:0] filter_channel(int unsigned sh);
        longint            acc;
        logic signed [15:0] k;
        logic [PIX_W-1:0]  p;
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                k = coef_rows[i][COEF_W*j +: COEF_W];
                p = PIX_W'(window[i*3+j] >> sh);
                acc += longint'(k) * longint'(p);
            end
        end
        if (acc <= 0)
            return '0;
        acc = acc >>> COEF_FRAC_BITS;
        return (acc > PIX_MAX) ? PIX_W'(PIX_MAX) : acc[PIX_W-1:0];
    endfunction

    function automatic void filter_pixel(pixel_t px);
        int unsigned w, h, idx;
        pixel_t      top, mid;
        logic        last_col, last_row;
        out_pixel_t  res;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        idx = (col_cnt < MAX_WIDTH) ? col_cnt : MAX_WIDTH - 1;
        top = line_upper[idx];
        mid = line_lower[idx];
        line_upper[idx] = mid;
        line_lower[idx] = px;
        window[0] = window[1]; window[1] = window[2]; window[2] = top;
        window[3] = window[4]; window[4] = window[5]; window[5] = mid;
        window[6] = window[7]; window[7] = window[8]; window[8] = px;
        last_col = col_cnt >= w - 1;
        last_row = row_cnt >= h - 1;
        if (row_cnt >= 2 && col_cnt >= 2)
        begin
            res.pix.red   = filter_channel(16);
            res.pix.green = filter_channel(8);
            res.pix.blue  = filter_channel(0);
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            filtered_q.push_back(res);
        end
        if (last_col)
        begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : (row_cnt + 1) & 10'h3FF;
        end
        else
            col_cnt = (col_cnt + 1) & 10'h3FF;
    endfunction

    function automatic int unsigned pixels_to_frame_end();
        int unsigned w, h, n;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        n = (col_cnt >= w - 1) ? 1 : w - col_cnt;
        if (row_cnt < h - 1)
            n += (h - 1 - row_cnt) * w;
        return n;
    endfunction

    function automatic int unsigned pick_gap(bit active);
        int unsigned r;
        if (!active)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic void push_pixels(int unsigned n);
        pixel_t px;
        repeat (n)
        begin
            px = pixel_t'($urandom);
            if ($urandom_range(0, 4) == 0)
            begin
                px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            pixel_q.push_back(px);
        end
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return DIM_W'($urandom_range(0, 2));
        if (r < 3)
            return DIM_W'($urandom_range(13, 40));
        return DIM_W'($urandom_range(3, 12));
    endfunction

    function automatic logic [CFG_W-1:0] rand_coef_row();
        logic [CFG_W-1:0] row;
        int               v;
        if ($urandom_range(0, 3) == 0)
            return {16'($urandom), 32'($urandom)};
        for (int j = 0; j < 3; j++)
        begin
            v = int'($urandom_range(0, 1200)) - 600;
            row[COEF_W*j +: COEF_W] = v[COEF_W-1:0];
        end
        return row;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_COEF_TOP:    coef_rows[0] = val;
            CFG_COEF_MIDDLE: coef_rows[1] = val;
            CFG_COEF_BOTTOM: coef_rows[2] = val;
            CFG_WIDTH:       width_reg = val[DIM_W-1:0];
            CFG_HEIGHT:      height_reg = val[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_axis_tvalid || filtered_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        logic offer;
        pixel_t px;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                filter_pixel(pixel_q.pop_front());
                pixels_sent++;
                send_gap = pick_gap(send_mode);
            end
            offer = 1'b0;
            if (send_gap != 0)
                send_gap--;
            else if (pixel_q.size() != 0)
                offer = 1'b1;
            s_axis_tvalid <= offer;
            if (offer)
            begin
                px = pixel_q[0];
                s_axis_tdata <= {px.blue, px.green, px.red};
            end
        end
    end

    // long output hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        out_pixel_t want;
        logic ready_next;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (filtered_q.size() == 0)
                    report_mismatch($sformatf("output beat %h with no result pending",
                                              m_axis_tdata));
                else
                begin
                    want = filtered_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.pix.red)
                        report_mismatch($sformatf("beat %0d red %h, want %h",
                                        beats_checked, m_axis_tdata[7:0], want.pix.red));
                    if (m_axis_tdata[15:8] !== want.pix.green)
                        report_mismatch($sformatf("beat %0d green %h, want %h",
                                        beats_checked, m_axis_tdata[15:8], want.pix.green));
                    if (m_axis_tdata[23:16] !== want.pix.blue)
                        report_mismatch($sformatf("beat %0d blue %h, want %h",
                                        beats_checked, m_axis_tdata[23:16], want.pix.blue));
                    if (m_axis_tlast !== want.row_end)
                        report_mismatch($sformatf("beat %0d row end %b, want %b",
                                        beats_checked, m_axis_tlast, want.row_end));
                    if (m_axis_tuser !== want.frame_end)
                        report_mismatch($sformatf("beat %0d frame end %b, want %b",
                                        beats_checked, m_axis_tuser, want.frame_end));
                    if (want.frame_end)
                        frame_ends++;
                end
                beats_checked++;
            end
            if (hold_left != 0)
                ready_next = 1'b0;
            else if (recv_stall != 0)
            begin
                recv_stall--;
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = 1'b1;
                if (recv_mode && $urandom_range(0, 3) == 0)
                    recv_stall = pick_gap(1'b1);
            end
            m_axis_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, filtered_q.size());
            $display("rgb_convolution_3x3 verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned      we, he, frames, k, n, random_pixels;
        logic [DIM_W-1:0] wr, hr;
        pixel_t           px;
        random_pixels = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset kernel passes the middle-row pixel of the oldest window column
        send_mode = 1'b1;
        recv_mode = 1'b1;
        write_reg(CFG_WIDTH, 48'd3);
        write_reg(CFG_HEIGHT, 48'd3);
        pixel_q.push_back(pixel_t'{8'h00, 8'hFF, 8'h00});
        pixel_q.push_back(pixel_t'{8'hFF, 8'h00, 8'hFF});
        pixel_q.push_back(pixel_t'{8'h01, 8'h80, 8'h7F});
        pixel_q.push_back(pixel_t'{8'hFE, 8'h01, 8'h00});
        pixel_q.push_back(pixel_t'{8'hFF, 8'h00, 8'h80});
        pixel_q.push_back(pixel_t'{8'h00, 8'h00, 8'h00});
        pixel_q.push_back(pixel_t'{8'hFF, 8'hFF, 8'hFF});
        pixel_q.push_back(pixel_t'{8'h55, 8'hAA, 8'h0F});
        pixel_q.push_back(pixel_t'{8'hF0, 8'h33, 8'hCC});
        wait_idle();

        // extreme coefficients: saturate high and drive sums negative
        write_reg(CFG_COEF_TOP,    {16'h0001, 16'h8000, 16'h7FFF});
        write_reg(CFG_COEF_MIDDLE, {16'h7FFF, 16'h0100, 16'hFFFF});
        write_reg(CFG_COEF_BOTTOM, {16'hFF00, 16'h0080, 16'h8000});
        write_reg(CFG_WIDTH, 48'd4);
        for (int i = 0; i < 12; i++)
        begin
            px.red   = i[0] ? 8'hFF : 8'h00;
            px.green = i[1] ? 8'hFF : 8'h00;
            px.blue  = i[2] ? 8'hFF : 8'h01;
            pixel_q.push_back(px);
        end
        wait_idle();

        // hold the output while pixels keep coming so the input stalls
        write_reg(CFG_COEF_TOP, rand_coef_row());
        write_reg(CFG_COEF_MIDDLE, rand_coef_row());
        write_reg(CFG_COEF_BOTTOM, rand_coef_row());
        write_reg(CFG_WIDTH, 48'd40);
        write_reg(CFG_HEIGHT, 48'd12);
        send_mode = 1'b0;
        recv_mode = 1'b0;
        hold_request <= 1'b1;
        push_pixels(40 * 12);
        wait_idle();

        // out-of-range sizes clamp; shrink partway so the frame stays short
        write_reg(CFG_WIDTH, 48'd2047);
        write_reg(CFG_HEIGHT, 48'd3);
        push_pixels(10);
        wait_idle();
        write_reg(CFG_WIDTH, 48'd5);
        n = pixels_to_frame_end();
        push_pixels(n);
        wait_idle();
        write_reg(CFG_WIDTH, 48'd1);
        write_reg(CFG_HEIGHT, 48'd2047);
        push_pixels(60);
        wait_idle();
        write_reg(CFG_HEIGHT, 48'd0);
        n = pixels_to_frame_end();
        push_pixels(n);
        wait_idle();

        while (random_pixels < RANDOM_PIXELS)
        begin
            wr = rand_dim();
            hr = rand_dim();
            write_reg(CFG_WIDTH, 48'(wr));
            write_reg(CFG_HEIGHT, 48'(hr));
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(CFG_COEF_TOP, rand_coef_row());
                write_reg(CFG_COEF_MIDDLE, rand_coef_row());
                write_reg(CFG_COEF_BOTTOM, rand_coef_row());
            end
            send_mode = $urandom_range(0, 3) != 0;
            recv_mode = $urandom_range(0, 3) != 0;
            we = eff_dim(wr);
            he = eff_dim(hr);
            frames = $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0 && (we > 3 || he > 3))
            begin
                // shrink the frame partway through
                k = $urandom_range(1, we * he - 1);
                push_pixels(k);
                wait_idle();
                if (we > 3 && (he == 3 || $urandom_range(0, 1) != 0))
                    write_reg(CFG_WIDTH, 48'($urandom_range(3, we - 1)));
                else
                    write_reg(CFG_HEIGHT, 48'($urandom_range(3, he - 1)));
                n = pixels_to_frame_end();
                push_pixels(n);
                random_pixels += k + n;
                resizes++;
            end
            else
            begin
                push_pixels(we * he * frames);
                random_pixels += we * he * frames;
            end
            wait_idle();
        end

        wait_idle();
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", filtered_q.size()));
        $display("covered %0d pixels in, %0d filtered beats checked, %0d frame ends",
                 pixels_sent, beats_checked, frame_ends);
        $display("frames 3 to 40 wide and high, clamped sizes, %0d random mid-frame shrinks",
                 resizes);
        if (error_count == 0)
            $display("rgb_convolution_3x3 verification clean");
        else
            $display("rgb_convolution_3x3 verification failed");
        $finish;
    end

endmodule

`default_nettype wire
